/* rtl/sset_pkg.sv */
// Shared constants and codes for the sorted set block.
package sset_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 6;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

endpackage

/* rtl/sorted_set_insert_delete_top.sv */
// Top level of the sorted set: sequencer, compare unit and entry store.
//
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in one
// RAM. A request is taken when start is high and busy is low; busy then stays
// high until the request is finished, but an empty read-out and code 3 leave it
// low. Inserts, deletes and read-outs of a non-empty store walk the RAM one entry
// a cycle through its single read port: insert and delete scan from the bottom
// until the first entry not below the value or the end of the store, then move
// the entries above that place by one slot, then store the new value for an
// insert. A read-out gives one word per cycle; an empty store gives one empty
// word. Each result word shows for one cycle under strobe and cannot be held off,
// so the receiver must take it in that cycle. Request code 3 is taken and
// ignored.
module sorted_set_insert_delete_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        req_type,
  input  logic signed [sset_pkg::DATA_W-1:0] value,
  output logic                              busy,
  output logic                              strobe,
  output logic [2:0]                        status,
  output logic signed [sset_pkg::DATA_W-1:0] entry_value,
  output logic                              last,
  output logic [sset_pkg::OUT_CNT_W-1:0]    entry_count
);

  import sset_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_READ
  } state_t;

  state_t                     state;
  logic [1:0]                 req;
  logic signed [DATA_W-1:0]   val;
  logic [CNT_W-1:0]           idx;
  logic [CNT_W-1:0]           pos;
  logic [CNT_W-1:0]           count;

  logic                       we;
  logic [ADDR_W-1:0]          wr_addr;
  logic [DATA_W-1:0]          wr_data;
  logic [ADDR_W-1:0]          rd_addr;
  logic [DATA_W-1:0]          rd_data;

  logic [CNT_W-1:0]           idx_inc;
  logic [CNT_W-1:0]           idx_dec;
  logic [CNT_W-1:0]           count_dec;
  logic                       at_end;
  logic                       less;
  logic                       hit;
  logic                       scan_on;

  sset_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit: the word on rd_data belongs to entry idx
  assign idx_inc   = CNT_W'(idx + 1'b1);
  assign idx_dec   = CNT_W'(idx - 1'b1);
  assign count_dec = CNT_W'(count - 1'b1);
  assign at_end    = (idx >= count);
  assign less      = ($signed(rd_data) < val);
  assign hit       = !at_end && (rd_data == val);
  assign scan_on   = !at_end && less;

  assign busy = (state != S_IDLE);

  // Drive RAM addresses and write strobe from the sequencer state
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = ADDR_W'(idx);
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
      end
      S_SEARCH: begin
        if (scan_on) begin
          rd_addr = ADDR_W'(idx_inc);
        end else if (req == REQ_INSERT) begin
          rd_addr = ADDR_W'(count_dec);
        end else begin
          rd_addr = ADDR_W'(idx_inc);
        end
      end
      S_SHIFT_UP: begin
        we      = 1'b1;
        wr_addr = ADDR_W'(idx_inc);
        rd_addr = ADDR_W'(idx_dec);
      end
      S_PUT: begin
        we      = 1'b1;
        wr_addr = ADDR_W'(pos);
        wr_data = val;
      end
      S_SHIFT_DN: begin
        we      = 1'b1;
        wr_addr = ADDR_W'(idx_dec);
        rd_addr = ADDR_W'(idx_inc);
      end
      S_READ: begin
        rd_addr = ADDR_W'(idx_inc);
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Sequencer: hold state, count and the registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= req_type;
            val <= value;
            idx <= '0;
            if (req_type == REQ_INSERT || req_type == REQ_DELETE) begin
              state <= S_SEARCH;
            end else if (req_type == REQ_READ) begin
              if (count == '0) begin
                strobe      <= 1'b1;
                status      <= ST_EMPTY;
                entry_value <= '0;
                last        <= 1'b1;
                entry_count <= OUT_CNT_W'(count);
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_SEARCH: begin
          if (scan_on) begin
            idx <= idx_inc;
          end else begin
            pos         <= idx;
            entry_value <= '0;
            last        <= 1'b1;
            if (req == REQ_INSERT) begin
              entry_count <= OUT_CNT_W'(count);
              if (hit) begin
                strobe <= 1'b1;
                status <= ST_DUPLICATE;
                state  <= S_IDLE;
              end else if (count >= CNT_W'(CAPACITY)) begin
                strobe <= 1'b1;
                status <= ST_FULL;
                state  <= S_IDLE;
              end else if (idx == count) begin
                state <= S_PUT;
              end else begin
                idx   <= count_dec;
                state <= S_SHIFT_UP;
              end
            end else begin
              if (!hit) begin
                strobe      <= 1'b1;
                status      <= ST_NOT_FOUND;
                entry_count <= OUT_CNT_W'(count);
                state       <= S_IDLE;
              end else if (idx_inc == count) begin
                strobe      <= 1'b1;
                status      <= ST_DELETED;
                count       <= count_dec;
                entry_count <= OUT_CNT_W'(count_dec);
                state       <= S_IDLE;
              end else begin
                idx   <= idx_inc;
                state <= S_SHIFT_DN;
              end
            end
          end
        end
        S_SHIFT_UP: begin
          // Move entry idx one slot up, walking down towards the insert place
          if (idx == pos) begin
            state <= S_PUT;
          end else begin
            idx <= idx_dec;
          end
        end
        S_PUT: begin
          strobe      <= 1'b1;
          status      <= ST_INSERTED;
          entry_value <= '0;
          last        <= 1'b1;
          count       <= CNT_W'(count + 1'b1);
          entry_count <= OUT_CNT_W'(count + 1'b1);
          state       <= S_IDLE;
        end
        S_SHIFT_DN: begin
          // Move entry idx one slot down, walking up to the top entry
          if (idx_inc == count) begin
            strobe      <= 1'b1;
            status      <= ST_DELETED;
            entry_value <= '0;
            last        <= 1'b1;
            count       <= count_dec;
            entry_count <= OUT_CNT_W'(count_dec);
            state       <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        S_READ: begin
          strobe      <= 1'b1;
          status      <= ST_ENTRY;
          entry_value <= rd_data;
          last        <= (idx_inc == count);
          entry_count <= OUT_CNT_W'(count);
          if (idx_inc == count) begin
            state <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  // A full drop is only reported with a full store
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_FULL |-> entry_count == OUT_CNT_W'(CAPACITY))
    else $error("full status with room left");

  // Anything but a read-out entry is a single, final word
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_ENTRY |-> last && entry_value == '0)
    else $error("single result word not marked last");

  // A finished insert grows the count by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow count by one");

endmodule

/* rtl/sset_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sim/sorted_set_checker.sv */
// Checker for the sorted set: predicts result words from accepted requests and compares them.
module sorted_set_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         req_type,
  input  logic signed [sset_pkg::DATA_W-1:0] value,
  input  logic                               strobe,
  input  logic [2:0]                         status,
  input  logic signed [sset_pkg::DATA_W-1:0] entry_value,
  input  logic                               last,
  input  logic [sset_pkg::OUT_CNT_W-1:0]     entry_count,
  output int                                 mismatch_count,
  output int                                 words_owed
);
  import sset_pkg::*;

  typedef struct {
    status_t                    status;
    logic signed [DATA_W-1:0]   entry_value;
    logic                       last;
    logic [OUT_CNT_W-1:0]       entry_count;
  } result_word_t;

  // Values held by the set, kept ascending
  logic signed [DATA_W-1:0] held_values[$];
  // Result words still to come, oldest first
  result_word_t             owed_words[$];

  initial begin
    mismatch_count = 0;
    words_owed     = 0;
  end

  // Queue one result word stamped with the count after the request
  function automatic void owe_word(input status_t st, input logic signed [DATA_W-1:0] v,
                                   input logic is_last);
    result_word_t w;
    w.status      = st;
    w.entry_value = v;
    w.last        = is_last;
    w.entry_count = OUT_CNT_W'(held_values.size());
    owed_words.push_back(w);
  endfunction

  // Apply one request to the held set and queue the words it causes
  function automatic void apply_request(input logic [1:0] req,
                                        input logic signed [DATA_W-1:0] v);
    int  place;
    bit  hit;
    place = 0;
    while (place < held_values.size() && held_values[place] < v)
      place++;
    hit = (place < held_values.size()) && (held_values[place] == v);
    case (req)
      REQ_INSERT: begin
        if (hit) begin
          owe_word(ST_DUPLICATE, '0, 1'b1);
        end else if (held_values.size() >= CAPACITY) begin
          owe_word(ST_FULL, '0, 1'b1);
        end else begin
          held_values.insert(place, v);
          owe_word(ST_INSERTED, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          held_values.delete(place);
          owe_word(ST_DELETED, '0, 1'b1);
        end else begin
          owe_word(ST_NOT_FOUND, '0, 1'b1);
        end
      end
      REQ_READ: begin
        if (held_values.size() == 0) begin
          owe_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_values.size(); i++)
            owe_word(ST_ENTRY, held_values[i], (i == held_values.size() - 1));
        end
      end
      default: ;
    endcase
  endfunction

  // Check each strobed word before taking a new request at the same edge
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst) begin
      held_values.delete();
      owed_words.delete();
    end else begin
      if (strobe) begin
        if (owed_words.size() == 0) begin
          $error("unexpected result word: status %0d entry_value %0d last %0d count %0d",
                 status, entry_value, last, entry_count);
          mismatch_count++;
        end else begin
          exp_word = owed_words.pop_front();
          if (status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, status);
            mismatch_count++;
          end
          if (entry_value !== exp_word.entry_value) begin
            $error("entry_value: expected %0d, got %0d", exp_word.entry_value, entry_value);
            mismatch_count++;
          end
          if (last !== exp_word.last) begin
            $error("last: expected %0d, got %0d", exp_word.last, last);
            mismatch_count++;
          end
          if (entry_count !== exp_word.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_word.entry_count, entry_count);
            mismatch_count++;
          end
        end
      end
      if (start && !busy)
        apply_request(req_type, value);
    end
    words_owed <= owed_words.size();
  end

endmodule

/* sim/tb_sorted_set_insert_delete_top.sv */
// Testbench top for the sorted set: drives requests and reports the verdict.
module tb_sorted_set_insert_delete_top;
  import sset_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               req_type = REQ_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] entry_value;
  logic                     last;
  logic [OUT_CNT_W-1:0]     entry_count;

  int mismatch_count;
  int words_owed;
  int cycle_count = 0;
  bit idling_on = 1'b1;

  // Values sent in inserts, reused to hit stored entries
  logic signed [DATA_W-1:0] written_values[$];

  sorted_set_insert_delete_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .value       (value),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .entry_value (entry_value),
    .last        (last),
    .entry_count (entry_count)
  );

  sorted_set_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .value          (value),
    .strobe         (strobe),
    .status         (status),
    .entry_value    (entry_value),
    .last           (last),
    .entry_count    (entry_count),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold a request until taken, then idle for a random burst now and then
  task automatic issue(input logic [1:0] code, input logic signed [DATA_W-1:0] v);
    start    <= 1'b1;
    req_type <= code;
    value    <= v;
    do @(posedge clk); while (busy);
    if (code == REQ_INSERT)
      written_values.push_back(v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Pick a value: an earlier insert, an edge value or a fresh random word
  function automatic logic signed [DATA_W-1:0] pick_value(input int reuse_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && written_values.size() > 0)
      return written_values[$urandom_range(0, written_values.size() - 1)];
    if (roll < reuse_pct + 10) begin
      case ($urandom_range(0, 4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        3: return -1;
        default: return VAL_MIN + 1;
      endcase
    end
    return $urandom;
  endfunction

  // Run a random mix of requests with the given weights in percent
  task automatic run_mix(input int items, input int ins_pct, input int del_pct,
                         input int rd_pct);
    int roll;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        issue(REQ_INSERT, pick_value(30));
      else if (roll < ins_pct + del_pct)
        issue(REQ_DELETE, pick_value(75));
      else if (roll < ins_pct + del_pct + rd_pct)
        issue(REQ_READ, $urandom);
      else
        issue(REQ_UNUSED, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, edge values, ordering, duplicates, unused code
    issue(REQ_READ, '0);
    issue(REQ_DELETE, 7);
    issue(REQ_INSERT, 0);
    issue(REQ_INSERT, VAL_MAX);
    issue(REQ_INSERT, VAL_MIN);
    issue(REQ_INSERT, -1);
    issue(REQ_INSERT, 1);
    issue(REQ_INSERT, 0);
    issue(REQ_READ, VAL_MAX);
    issue(REQ_UNUSED, VAL_MAX);
    issue(REQ_DELETE, VAL_MIN);
    issue(REQ_DELETE, VAL_MAX);
    issue(REQ_DELETE, 0);
    issue(REQ_DELETE, 0);
    issue(REQ_READ, '0);
    issue(REQ_DELETE, -1);
    issue(REQ_DELETE, 1);
    issue(REQ_READ, VAL_MIN);

    // Fill past capacity, then duplicate and overflow while full
    repeat (CAPACITY + 2)
      issue(REQ_INSERT, $urandom);
    issue(REQ_READ, '0);
    // Reuse one of the values that went into the full store
    issue(REQ_INSERT,
          written_values[written_values.size() - 3 - $urandom_range(0, CAPACITY - 1)]);
    issue(REQ_INSERT, VAL_MIN);
    issue(REQ_READ, '0);

    // Drain mostly by deleting stored values
    run_mix(40, 15, 70, 12);

    // Final stretch with no idling
    idling_on = 1'b0;
    run_mix(35, 40, 35, 20);
    start <= 1'b0;

    // Wait for every owed word, then let the block settle
    do @(posedge clk); while (words_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
rtl/sset_pkg.sv
rtl/sset_ram.sv
rtl/sorted_set_insert_delete_top.sv
sim/sorted_set_checker.sv
sim/tb_sorted_set_insert_delete_top.sv
